// ===== src/spr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slotted page record store package
// Page geometry, derived widths, item and status codes, descriptor layout.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int unsigned AREA_BYTES  = 4091;
  localparam int unsigned DESC_BYTES  = 10;
  localparam int unsigned MAX_RECORDS = 256;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned AREA_W  = $clog2(AREA_BYTES + 1);
  localparam int unsigned DATA_AW = $clog2(AREA_BYTES);
  localparam int unsigned DESC_AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_RECORDS + 1);
  localparam int unsigned CMP_W   = ((AREA_W > LEN_W) ? AREA_W : LEN_W) + 1;

  typedef enum logic [2:0] {
    KIND_INIT        = 3'd0,
    KIND_FIND        = 3'd1,
    KIND_WRITE_BEGIN = 3'd2,
    KIND_WRITE_BYTE  = 3'd3,
    KIND_DELETE      = 3'd4,
    KIND_UPDATE      = 3'd5,
    KIND_READ_BYTE   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_STRAY     = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [AREA_W-1:0] len;
  } desc_t;

endpackage
`default_nettype wire

// ===== src/slotted_page_record_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slotted page record store
// One page of packed records with a key/length descriptor table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command transaction:
//   init, find, write_begin, write_byte, delete, update_begin, read_byte.
//   Every command returns exactly one result transaction on the output
//   channel (out_valid_o/out_ready_i), in order.
// Command flow:
//   write_begin, write_byte, an unused kind and a lookup on an empty page
//   finish at dispatch. read_byte returns one data byte (zero at or above the
//   fill level). find walks the descriptors (one descriptor RAM read a cycle);
//   update with the same length walks as find. delete walks, shifts the
//   descriptors above the record down, moves the data bytes above the record
//   down (one data RAM access a cycle) and zeroes the freed bytes; update with
//   a new length does the same and then appends. init zeroes the fill bytes.
// One command is in flight at a time; the next is taken once the result is
// registered, even if the receiver has not yet taken it. A stalled receiver
// holds the result; the following command then waits before its result.
// Reset: a clearing pass zeroes all AREA_BYTES data bytes before in_ready_o
// rises. Bytes at or above the fill level stay zero.
// ----------------------------------------------------------------------------
module slotted_page_record_store (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] record_key_i,
  input  wire logic [11:0] record_length_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [11:0] byte_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic             found_o,
  output logic [11:0]      record_offset_o,
  output logic [11:0]      found_length_o,
  output logic [7:0]       desc_index_o,
  output logic [7:0]       read_data_o,
  output logic [11:0]      free_space_o,
  output logic             dirty_o
);

  localparam int unsigned AW  = spr_pkg::AREA_W;
  localparam int unsigned CW  = spr_pkg::CNT_W;
  localparam int unsigned MW  = spr_pkg::CMP_W;
  localparam int unsigned DBW = $bits(spr_pkg::desc_t);

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_DISP, S_SRCH, S_DSHIFT, S_DCOPY, S_ZERO, S_APPEND, S_RD, S_DONE
  } state_e;

  state_e state_q;

  // latched command
  logic [2:0]           kind_q;
  logic [63:0]          key_q;
  logic [11:0]          len_q;
  logic [7:0]           byte_q;
  logic [11:0]          roff_q;

  // page bookkeeping
  logic [CW-1:0]        count_q;
  logic [AW-1:0]        fill_q, free_q, wp_q, wrem_q;
  logic                 dirty_q;

  // walk and move machinery
  logic [CW-1:0]        iss_q, pidx_q, m_q;
  logic                 pend_q;
  logic [AW-1:0]        sum_q, moff_q, mlen_q;
  logic [AW-1:0]        cp_q, cpaddr_q;
  logic                 cpend_q;
  logic [AW-1:0]        zptr_q, zend_q;

  // result holding
  logic [1:0]           r_status_q;
  logic                 r_found_q;
  logic [7:0]           r_rdata_q;
  logic                 out_valid_q;

  // memory ports
  logic                        d_we, d_re;
  logic [spr_pkg::DATA_AW-1:0] d_waddr, d_raddr;
  logic [7:0]                  d_wdata, d_rdata;
  logic                        k_we, k_re;
  logic [spr_pkg::DESC_AW-1:0] k_waddr, k_raddr;
  spr_pkg::desc_t              k_wdata, k_rdata;

  logic          desc_issue, copy_issue, zero_act, app_go, can_emit;
  logic          wbyte_ok, rd_inside, hit, last;
  logic [CW-1:0] shift_dst;
  logic [AW-1:0] copy_dst;

  assign can_emit   = !out_valid_q || out_ready_i;
  assign desc_issue = (state_q == S_SRCH || state_q == S_DSHIFT) && (iss_q < count_q);
  assign copy_issue = (state_q == S_DCOPY) && (cp_q < fill_q);
  assign zero_act   = (state_q == S_ZERO || state_q == S_BOOT) && (zptr_q < zend_q);
  assign app_go     = (count_q < CW'(spr_pkg::MAX_RECORDS)) &&
                      ((MW'(len_q) + MW'(spr_pkg::DESC_BYTES)) <= MW'(free_q));
  assign wbyte_ok   = (wrem_q != '0) && (MW'(wp_q) < MW'(spr_pkg::AREA_BYTES));
  assign rd_inside  = MW'(roff_q) < MW'(fill_q);
  assign hit        = (k_rdata.key == key_q);
  assign last       = (pidx_q == count_q - CW'(1));
  assign shift_dst  = pidx_q - CW'(1);
  assign copy_dst   = cpaddr_q - mlen_q;

  // Memory port steering: only one phase touches each RAM at a time.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    d_re    = 1'b0;
    d_raddr = spr_pkg::DATA_AW'(cp_q);
    if (state_q == S_DISP && kind_q == spr_pkg::KIND_WRITE_BYTE && wbyte_ok) begin
      d_we    = 1'b1;
      d_waddr = spr_pkg::DATA_AW'(wp_q);
      d_wdata = byte_q;
    end else if (state_q == S_DCOPY && cpend_q) begin
      d_we    = 1'b1;
      d_waddr = spr_pkg::DATA_AW'(copy_dst);
      d_wdata = d_rdata;
    end else if (zero_act) begin
      d_we    = 1'b1;
      d_waddr = spr_pkg::DATA_AW'(zptr_q);
    end
    if (state_q == S_DISP && kind_q == spr_pkg::KIND_READ_BYTE) begin
      d_re    = rd_inside;
      d_raddr = spr_pkg::DATA_AW'(roff_q);
    end else begin
      d_re    = copy_issue;
    end

    k_re    = desc_issue;
    k_raddr = iss_q[spr_pkg::DESC_AW-1:0];
    k_we    = 1'b0;
    k_waddr = count_q[spr_pkg::DESC_AW-1:0];
    k_wdata = '{key: key_q, len: AW'(len_q)};
    if (state_q == S_DSHIFT && pend_q) begin
      k_we    = 1'b1;
      k_waddr = shift_dst[spr_pkg::DESC_AW-1:0];
      k_wdata = k_rdata;
    end else if (app_go && ((state_q == S_APPEND) ||
                 (state_q == S_DISP && kind_q == spr_pkg::KIND_WRITE_BEGIN))) begin
      k_we    = 1'b1;
    end
  end

  spr_ram #(.WIDTH(8), .DEPTH(spr_pkg::AREA_BYTES)) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .waddr_i(d_waddr),
    .wdata_i(d_wdata),
    .re_i   (d_re),
    .raddr_i(d_raddr),
    .rdata_o(d_rdata)
  );

  spr_ram #(.WIDTH(DBW), .DEPTH(spr_pkg::MAX_RECORDS)) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (k_we),
    .waddr_i(k_waddr),
    .wdata_i(k_wdata),
    .re_i   (k_re),
    .raddr_i(k_raddr),
    .rdata_o(k_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_BOOT;
      kind_q          <= '0;
      key_q           <= '0;
      len_q           <= '0;
      byte_q          <= '0;
      roff_q          <= '0;
      count_q         <= '0;
      fill_q          <= '0;
      free_q          <= AW'(spr_pkg::AREA_BYTES);
      wp_q            <= '0;
      wrem_q          <= '0;
      dirty_q         <= 1'b1;
      iss_q           <= '0;
      pidx_q          <= '0;
      m_q             <= '0;
      pend_q          <= 1'b0;
      sum_q           <= '0;
      moff_q          <= '0;
      mlen_q          <= '0;
      cp_q            <= '0;
      cpaddr_q        <= '0;
      cpend_q         <= 1'b0;
      zptr_q          <= '0;
      zend_q          <= AW'(spr_pkg::AREA_BYTES);
      r_status_q      <= spr_pkg::ST_OK;
      r_found_q       <= 1'b0;
      r_rdata_q       <= '0;
      out_valid_q     <= 1'b0;
      status_o        <= '0;
      found_o         <= 1'b0;
      record_offset_o <= '0;
      found_length_o  <= '0;
      desc_index_o    <= '0;
      read_data_o     <= '0;
      free_space_o    <= '0;
      dirty_o         <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // stream bookkeeping for the descriptor and byte movers
      pend_q   <= desc_issue;
      pidx_q   <= iss_q;
      if (desc_issue) begin
        iss_q <= iss_q + CW'(1);
      end
      cpend_q  <= copy_issue;
      cpaddr_q <= cp_q;
      if (copy_issue) begin
        cp_q <= cp_q + AW'(1);
      end
      if (zero_act) begin
        zptr_q <= zptr_q + AW'(1);
      end

      unique case (state_q)
        S_BOOT: begin
          if (!zero_act) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q     <= kind_i;
            key_q      <= record_key_i;
            len_q      <= record_length_i;
            byte_q     <= data_byte_i;
            roff_q     <= byte_offset_i;
            r_status_q <= spr_pkg::ST_OK;
            r_found_q  <= 1'b0;
            r_rdata_q  <= '0;
            state_q    <= S_DISP;
          end
        end
        S_DISP: begin
          state_q <= S_DONE;
          iss_q   <= '0;
          sum_q   <= '0;
          case (kind_q) inside
            spr_pkg::KIND_INIT: begin
              wrem_q  <= '0;
              zptr_q  <= '0;
              zend_q  <= fill_q;
              count_q <= '0;
              fill_q  <= '0;
              free_q  <= AW'(spr_pkg::AREA_BYTES);
              wp_q    <= '0;
              dirty_q <= 1'b1;
              state_q <= S_ZERO;
            end
            spr_pkg::KIND_FIND, spr_pkg::KIND_DELETE, spr_pkg::KIND_UPDATE: begin
              if (kind_q != spr_pkg::KIND_FIND) begin
                wrem_q <= '0;
              end
              if (count_q == '0) begin
                r_status_q <= spr_pkg::ST_NOT_FOUND;
              end else begin
                state_q <= S_SRCH;
              end
            end
            spr_pkg::KIND_WRITE_BEGIN: begin
              wrem_q <= '0;
              if (app_go) begin
                count_q <= count_q + CW'(1);
                wp_q    <= fill_q;
                wrem_q  <= AW'(len_q);
                fill_q  <= fill_q + AW'(len_q);
                free_q  <= free_q - AW'(len_q) - AW'(spr_pkg::DESC_BYTES);
                dirty_q <= 1'b1;
              end else begin
                r_status_q <= spr_pkg::ST_NO_SPACE;
              end
            end
            spr_pkg::KIND_WRITE_BYTE: begin
              if (wbyte_ok) begin
                wp_q    <= wp_q + AW'(1);
                wrem_q  <= wrem_q - AW'(1);
                dirty_q <= 1'b1;
              end else begin
                r_status_q <= spr_pkg::ST_STRAY;
              end
            end
            spr_pkg::KIND_READ_BYTE: begin
              state_q <= S_RD;
            end
            default: begin
            end
          endcase
        end
        S_SRCH: begin
          if (pend_q) begin
            if (hit) begin
              m_q    <= pidx_q;
              moff_q <= sum_q;
              mlen_q <= k_rdata.len;
              iss_q  <= pidx_q + CW'(1);
              pend_q <= 1'b0;
              if (kind_q == spr_pkg::KIND_FIND) begin
                r_found_q <= 1'b1;
                state_q   <= S_DONE;
              end else if (kind_q == spr_pkg::KIND_UPDATE &&
                           MW'(k_rdata.len) == MW'(len_q)) begin
                wp_q    <= sum_q;
                wrem_q  <= AW'(len_q);
                dirty_q <= 1'b1;
                state_q <= S_DONE;
              end else begin
                state_q <= S_DSHIFT;
              end
            end else if (last) begin
              r_status_q <= spr_pkg::ST_NOT_FOUND;
              state_q    <= S_DONE;
            end else begin
              sum_q <= sum_q + k_rdata.len;
            end
          end
        end
        S_DSHIFT: begin
          if (!desc_issue && !pend_q) begin
            count_q <= count_q - CW'(1);
            cp_q    <= moff_q + mlen_q;
            cpend_q <= 1'b0;
            state_q <= S_DCOPY;
          end
        end
        S_DCOPY: begin
          if (!copy_issue && !cpend_q) begin
            zptr_q  <= fill_q - mlen_q;
            zend_q  <= fill_q;
            fill_q  <= fill_q - mlen_q;
            free_q  <= free_q + mlen_q + AW'(spr_pkg::DESC_BYTES);
            dirty_q <= 1'b1;
            state_q <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (!zero_act) begin
            state_q <= (kind_q == spr_pkg::KIND_UPDATE) ? S_APPEND : S_DONE;
          end
        end
        S_APPEND: begin
          if (app_go) begin
            count_q <= count_q + CW'(1);
            wp_q    <= fill_q;
            wrem_q  <= AW'(len_q);
            fill_q  <= fill_q + AW'(len_q);
            free_q  <= free_q - AW'(len_q) - AW'(spr_pkg::DESC_BYTES);
            dirty_q <= 1'b1;
          end else begin
            r_status_q <= spr_pkg::ST_NO_SPACE;
          end
          state_q <= S_DONE;
        end
        S_RD: begin
          r_rdata_q <= rd_inside ? d_rdata : 8'd0;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          // hold here until the output register is free
          if (can_emit) begin
            out_valid_q     <= 1'b1;
            status_o        <= r_status_q;
            found_o         <= r_found_q;
            record_offset_o <= r_found_q ? 12'(moff_q) : 12'd0;
            found_length_o  <= r_found_q ? 12'(mlen_q) : 12'd0;
            desc_index_o    <= r_found_q ? 8'(m_q) : 8'd0;
            read_data_o     <= r_rdata_q;
            free_space_o    <= 12'(free_q);
            dirty_o         <= dirty_q;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Space accounting balances whenever no command is in flight.
  a_space_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |->
      32'(free_q) + 32'(fill_q) + 32'(count_q) * spr_pkg::DESC_BYTES == spr_pkg::AREA_BYTES)
    else $error("page space accounting out of balance");

  // An open write window never reaches past the filled area.
  a_window_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrem_q != '0 |-> 32'(wp_q) + 32'(wrem_q) <= 32'(fill_q))
    else $error("write window extends past fill level");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= spr_pkg::MAX_RECORDS)
    else $error("record count above capacity");

  // Only one command in flight.
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while one in flight");

endmodule
`default_nettype wire

// ===== src/spr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
